@@ sv/thbp_pkg.sv @@
// shared types, codes and helpers of the timestamped heap buffer placer
`default_nettype none
package thbp_pkg;

    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int SIZE_W     = 17;
    localparam int BPH_W      = 25;
    localparam int OFFSET_W   = 40;
    localparam int SEQ_W      = 32;
    localparam int STATUS_W   = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_START_SAMPLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_GIVEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_RATIO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_HEAP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAPS_BUFFER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_HEAP   = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_PLACED   = 3'd0;
    localparam logic [STATUS_W-1:0] STS_LATE     = 3'd1;
    localparam logic [STATUS_W-1:0] STS_EARLY    = 3'd2;
    localparam logic [STATUS_W-1:0] STS_NOT_DATA = 3'd3;
    localparam logic [STATUS_W-1:0] STS_STOP     = 3'd4;
    localparam logic [STATUS_W-1:0] STS_IGNORED  = 3'd5;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] start_sample;
        logic                  start_given;
        logic [SIZE_W-1:0]     adc_ratio;
        logic [SIZE_W-1:0]     heap_samples;
        logic [SIZE_W-1:0]     heaps_per_buffer;
        logic [BPH_W-1:0]      heap_bytes;
    } t_cfg;

    // a size written as zero behaves as one
    function automatic logic [SIZE_W-1:0] at_least_one(input logic [SIZE_W-1:0] v);
        return (v == '0) ? SIZE_W'(1) : v;
    endfunction

endpackage
`default_nettype wire

@@ sv/thbp_front.sv @@
// front part: accepts items, learns the start sample and classifies heaps
`default_nettype none
module thbp_front
    import thbp_pkg::*;
#(
    parameter int TW = 48
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  t_cfg          i_cfg,
    input  wire           i_valid,
    output logic          o_ready,
    input  wire           i_cmd,
    input  wire           i_has_samples,
    input  wire  [TW-1:0] i_ts,
    input  wire           i_full,
    output logic          o_push,
    output logic          o_cmd,
    output logic          o_data_ok,
    output logic [TW-1:0] o_adc
);

    logic [TW-1:0] r_learned;
    logic          r_known;
    logic          w_learn;
    logic [TW-1:0] w_start;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    assign w_learn = o_push && !i_cmd && !i_cfg.start_given && !r_known && (i_ts != '0);

    // the heap that teaches the start is measured against itself
    always_comb begin
        if (i_cfg.start_given) begin
            w_start = TW'(i_cfg.start_sample);
        end else if (w_learn) begin
            w_start = i_ts;
        end else begin
            w_start = r_learned;
        end
    end

    assign o_cmd     = i_cmd;
    assign o_data_ok = i_has_samples && (i_ts != '0) && (i_ts >= w_start);
    assign o_adc     = i_ts - w_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learned <= '0;
            r_known   <= 1'b0;
        end else if (w_learn) begin
            r_learned <= i_ts;
            r_known   <= 1'b1;
        end
    end

endmodule
`default_nettype wire

@@ sv/thbp_fifo.sv @@
// two-entry queue between the front and the back part
`default_nettype none
module thbp_fifo #(
    parameter int W = 50
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  wire  [W-1:0] i_data,
    output logic         o_full,
    output logic         o_valid,
    input  wire          i_pop,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

@@ sv/thbp_div.sv @@
// iterative restoring divider, two quotient bits per cycle, narrow divisor
`default_nettype none
module thbp_div
    import thbp_pkg::*;
#(
    parameter int TW = 48
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire  [TW-1:0]     i_dividend,
    input  wire  [SIZE_W-1:0] i_divisor,
    output logic              o_done,
    output logic [TW-1:0]     o_quotient
);

    localparam int STEPS = (TW + 1) / 2;
    localparam int DW    = 2 * STEPS;
    localparam int CW    = $clog2(STEPS + 1);

    logic [DW-1:0]     r_quo;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] r_div;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DW-1:0]     n_quo;
    logic [SIZE_W-1:0] n_rem;

    always_comb begin
        logic [SIZE_W:0] trial;
        logic            qbit;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            trial = {n_rem, n_quo[DW-1]};
            qbit  = (trial >= {1'b0, r_div});
            if (qbit) begin
                n_rem = SIZE_W'(trial - {1'b0, r_div});
            end else begin
                n_rem = trial[SIZE_W-1:0];
            end
            n_quo = {n_quo[DW-2:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= DW'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[TW-1:0];

endmodule
`default_nettype wire

@@ sv/thbp_back.sv @@
// back part: heap number, buffer window bookkeeping and result register
`default_nettype none
module thbp_back
    import thbp_pkg::*;
#(
    parameter int TW = 48
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  t_cfg                i_cfg,
    input  wire                 i_q_valid,
    output logic                o_q_pop,
    input  wire                 i_q_cmd,
    input  wire                 i_q_data_ok,
    input  wire  [TW-1:0]       i_q_adc,
    output logic                o_m_valid,
    input  wire                 i_m_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [TW-1:0]       o_heap,
    output logic [OFFSET_W-1:0] o_offset,
    output logic [SEQ_W-1:0]    o_buffer_number,
    output logic                o_buffer_closed,
    output logic                o_run_ended
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV_A = 3'd1;
    localparam logic [2:0] ST_DIV_B = 3'd2;
    localparam logic [2:0] ST_CLASS = 3'd3;
    localparam logic [2:0] ST_PROD  = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0]          r_state;
    logic [TW-1:0]       r_first;
    logic [TW-1:0]       r_end;
    logic [SIZE_W-1:0]   r_heaps;
    logic                r_roll;
    logic                r_open;
    logic                r_over;
    logic [SEQ_W-1:0]    r_seq;

    logic [STATUS_W-1:0] r_status;
    logic [TW-1:0]       r_heap;
    logic [SIZE_W-1:0]   r_diff;
    logic [OFFSET_W-1:0] r_prod;
    logic                r_ended;
    logic                r_arrival;
    logic                r_closed_stop;

    logic                r_m_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [TW-1:0]       r_o_heap;
    logic [OFFSET_W-1:0] r_o_offset;
    logic [SEQ_W-1:0]    r_o_seq;
    logic                r_o_closed;
    logic                r_o_ended;

    logic [SIZE_W-1:0]   w_hpb;
    logic [BPH_W-1:0]    w_bph;
    logic                w_div_start;
    logic [TW-1:0]       w_div_dividend;
    logic [SIZE_W-1:0]   w_div_divisor;
    logic                w_div_done;
    logic [TW-1:0]       w_div_quotient;
    logic                w_in_win;
    logic [TW-1:0]       w_diff;
    logic [TW-1:0]       w_heap_next;
    logic [SIZE_W+BPH_W-1:0] w_prod;
    logic                w_slot;
    logic                w_closed;
    logic                w_load;

    assign w_hpb = at_least_one(i_cfg.heaps_per_buffer);
    assign w_bph = (i_cfg.heap_bytes == '0) ? BPH_W'(1) : i_cfg.heap_bytes;

    assign o_q_pop = (r_state == ST_IDLE) && i_q_valid;

    // first division by the adc ratio, then by samples per heap
    assign w_div_start = (o_q_pop && !r_over && !i_q_cmd && i_q_data_ok)
                      || ((r_state == ST_DIV_A) && w_div_done);
    assign w_div_dividend = (r_state == ST_IDLE) ? i_q_adc : w_div_quotient;
    assign w_div_divisor  = (r_state == ST_IDLE) ? at_least_one(i_cfg.adc_ratio)
                                                 : at_least_one(i_cfg.heap_samples);

    thbp_div #(
        .TW(TW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quotient)
    );

    assign w_in_win    = (r_heap >= r_first) && (r_heap < r_end);
    assign w_diff      = r_heap - r_first;
    assign w_heap_next = r_heap + TW'(1);
    assign w_prod      = (SIZE_W + BPH_W)'(r_diff) * (SIZE_W + BPH_W)'(w_bph);
    assign w_slot      = !r_m_valid || i_m_ready;
    assign w_load      = (r_state == ST_FIN) && w_slot;
    assign w_closed    = r_arrival ? ((r_heaps == w_hpb) || r_roll || r_ended)
                                   : r_closed_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_first   <= '0;
            r_end     <= '0;
            r_heaps   <= '0;
            r_roll    <= 1'b0;
            r_open    <= 1'b0;
            r_over    <= 1'b0;
            r_seq     <= '1;
            r_m_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_heap <= '0;
                        r_diff <= '0;
                        if (r_over) begin
                            r_status      <= STS_IGNORED;
                            r_ended       <= 1'b0;
                            r_arrival     <= 1'b0;
                            r_closed_stop <= 1'b0;
                            r_state       <= ST_PROD;
                        end else if (i_q_cmd) begin
                            r_status      <= STS_STOP;
                            r_ended       <= 1'b1;
                            r_arrival     <= 1'b0;
                            r_over        <= 1'b1;
                            r_closed_stop <= r_open;
                            r_open        <= 1'b0;
                            r_state       <= ST_PROD;
                        end else begin
                            r_status      <= STS_NOT_DATA;
                            r_arrival     <= 1'b1;
                            r_closed_stop <= 1'b0;
                            if (!r_open) begin
                                // open the next buffer; an empty previous one ends the run
                                r_seq   <= r_seq + SEQ_W'(1);
                                r_ended <= (r_heaps == '0) && (r_end != '0);
                                r_first <= r_end;
                                r_end   <= r_end + TW'(w_hpb);
                                r_heaps <= '0;
                                r_roll  <= 1'b0;
                                r_open  <= 1'b1;
                            end else begin
                                r_ended <= 1'b0;
                            end
                            r_state <= i_q_data_ok ? ST_DIV_A : ST_PROD;
                        end
                    end
                end
                ST_DIV_A: begin
                    if (w_div_done) begin
                        r_state <= ST_DIV_B;
                    end
                end
                ST_DIV_B: begin
                    if (w_div_done) begin
                        r_heap  <= w_div_quotient;
                        r_state <= ST_CLASS;
                    end
                end
                ST_CLASS: begin
                    if (w_in_win) begin
                        r_status <= STS_PLACED;
                        r_diff   <= w_diff[SIZE_W-1:0];
                        r_heaps  <= r_heaps + SIZE_W'(1);
                        if (w_heap_next == r_end) begin
                            r_roll <= 1'b1;
                        end
                    end else if (r_heap < r_first) begin
                        r_status <= STS_LATE;
                    end else begin
                        r_status <= STS_EARLY;
                        r_roll   <= 1'b1;
                    end
                    r_state <= ST_PROD;
                end
                ST_PROD: begin
                    r_prod  <= w_prod[OFFSET_W-1:0];
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (w_slot) begin
                        if (r_arrival && w_closed) begin
                            r_open <= 1'b0;
                        end
                        if (r_arrival && r_ended) begin
                            r_over <= 1'b1;
                        end
                        r_o_status <= r_status;
                        r_o_heap   <= r_heap;
                        r_o_offset <= r_prod;
                        r_o_seq    <= r_seq;
                        r_o_closed <= w_closed;
                        r_o_ended  <= r_ended;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_valid       = r_m_valid;
    assign o_status        = r_o_status;
    assign o_heap          = r_o_heap;
    assign o_offset        = r_o_offset;
    assign o_buffer_number = r_o_seq;
    assign o_buffer_closed = r_o_closed;
    assign o_run_ended     = r_o_ended;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV_A || r_state == ST_DIV_B))
        else $error("divider finished outside a division state");

    a_over_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_over |=> r_over)
        else $error("end of acquisition was cleared");

    a_stop_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_o_status == STS_STOP) |-> r_o_ended)
        else $error("stop result without run end");

    a_ignored_after_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && r_over) |=> (r_status == STS_IGNORED))
        else $error("item after end of acquisition not ignored");

endmodule
`default_nettype wire

@@ sv/timestamped_heap_buffer_placer_unit.sv @@
// top level of the timestamped heap buffer placer
// Each accepted heap transfer yields exactly one result transfer. A data heap with
// a valid timestamp takes two divisions on one shared divider that retires two
// quotient bits per cycle, then classification and the offset product; stop commands,
// non-data heaps and items after the end of the run skip the divisions. A two-entry
// queue lets the input keep accepting while the back part works and a result waits
// at the output register. Configuration must be written by the user while no item is
// in flight, which the block does not enforce; sizes written as zero act as one.
`default_nettype none
module timestamped_heap_buffer_placer_unit
    import thbp_pkg::*;
#(
    parameter int TIMESTAMP_WIDTH = 48
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    // timestamp
    input  wire  [((TIMESTAMP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // cmd, has_samples
    input  wire  [1:0]              s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    // heap_number, offset, buffer_number, buffer_closed, run_ended
    output logic [((TIMESTAMP_WIDTH+74+7)/8)*8-1:0] m_axis_tdata,
    // status
    output logic [STATUS_W-1:0]     m_axis_tuser
);

    localparam int TW        = TIMESTAMP_WIDTH;
    localparam int OUT_W     = ((TW + 74 + 7) / 8) * 8;
    localparam int PAYLOAD_W = TW + 74;
    localparam int ITEM_W    = TW + 2;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_sample     <= '0;
            r_cfg.start_given      <= 1'b0;
            r_cfg.adc_ratio        <= SIZE_W'(1);
            r_cfg.heap_samples     <= SIZE_W'(1);
            r_cfg.heaps_per_buffer <= SIZE_W'(1);
            r_cfg.heap_bytes       <= BPH_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_SAMPLE: r_cfg.start_sample     <= i_cfg_data;
                CFG_START_GIVEN:  r_cfg.start_given      <= i_cfg_data[0];
                CFG_ADC_RATIO:    r_cfg.adc_ratio        <= i_cfg_data[SIZE_W-1:0];
                CFG_SAMPLES_HEAP: r_cfg.heap_samples     <= i_cfg_data[SIZE_W-1:0];
                CFG_HEAPS_BUFFER: r_cfg.heaps_per_buffer <= i_cfg_data[SIZE_W-1:0];
                CFG_BYTES_HEAP:   r_cfg.heap_bytes       <= i_cfg_data[BPH_W-1:0];
                default: ;
            endcase
        end
    end

    logic              w_push;
    logic              w_full;
    logic              w_f_cmd;
    logic              w_f_data_ok;
    logic [TW-1:0]     w_f_adc;
    logic              w_q_valid;
    logic              w_q_pop;
    logic [ITEM_W-1:0] w_q_data;

    logic [TW-1:0]       w_heap;
    logic [OFFSET_W-1:0] w_offset;
    logic [SEQ_W-1:0]    w_seq;
    logic                w_closed;
    logic                w_ended;

    thbp_front #(
        .TW(TW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_cmd         (s_axis_tuser[0]),
        .i_has_samples (s_axis_tuser[1]),
        .i_ts          (s_axis_tdata[TW-1:0]),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_cmd         (w_f_cmd),
        .o_data_ok     (w_f_data_ok),
        .o_adc         (w_f_adc)
    );

    thbp_fifo #(
        .W(ITEM_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_cmd, w_f_data_ok, w_f_adc}),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data)
    );

    thbp_back #(
        .TW(TW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (w_q_valid),
        .o_q_pop         (w_q_pop),
        .i_q_cmd         (w_q_data[ITEM_W-1]),
        .i_q_data_ok     (w_q_data[ITEM_W-2]),
        .i_q_adc         (w_q_data[TW-1:0]),
        .o_m_valid       (m_axis_tvalid),
        .i_m_ready       (m_axis_tready),
        .o_status        (m_axis_tuser),
        .o_heap          (w_heap),
        .o_offset        (w_offset),
        .o_buffer_number (w_seq),
        .o_buffer_closed (w_closed),
        .o_run_ended     (w_ended)
    );

    // zero fill up to whole bytes
    assign m_axis_tdata = OUT_W'(PAYLOAD_W'({w_ended, w_closed, w_seq, w_offset, w_heap}));

endmodule
`default_nettype wire
